/* hdl/bounded_array_list_engine_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the bounded array list engine
// Shared property wrappers; each use expands to one labeled assertion.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_ARRAY_LIST_ENGINE_DEFINES_SVH
`define BOUNDED_ARRAY_LIST_ENGINE_DEFINES_SVH

// Same-cycle implication, checked outside of reset.
`define BALE_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside of reset.
`define BALE_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/bale_pkg.sv */
// ----------------------------------------------------------------------------
// bale_pkg
// Types, constants and a helper function shared by the list engine modules.
// ----------------------------------------------------------------------------
`default_nettype none

package bale_pkg;

    // Default list capacity in entries.
    localparam int CAPACITY_DEF = 64;

    // Field widths.
    localparam int OPCODE_W  = 3;
    localparam int INDEX_W   = 6;
    localparam int VALUE_W   = 64;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 7;
    localparam int CFG_W     = 4;
    localparam int NUM_BYTES = VALUE_W / 8;

    // Entry width register value after reset.
    localparam logic [CFG_W-1:0] ENTRY_BYTES_RST = CFG_W'(8);

    // Command codes.
    typedef enum logic [OPCODE_W-1:0] {
        OP_APPEND       = 3'd0,
        OP_REMOVE_LAST  = 3'd1,
        OP_REMOVE_FIRST = 3'd2,
        OP_READ         = 3'd3,
        OP_OVERWRITE    = 3'd4,
        OP_INSERT       = 3'd5,
        OP_REMOVE_AT    = 3'd6,
        OP_CLEAR        = 3'd7
    } opcode_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_WIDE  = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    // Work that a decoded command needs from the entry memory.
    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_READ,
        ACT_PUT,
        ACT_SHIFT_DN,
        ACT_SHIFT_UP,
        ACT_FILL
    } act_t;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_RUN,
        S_READ_WAIT,
        S_SWEEP,
        S_PUT,
        S_FINISH
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic rd_issue;
        logic rd_cap;
        logic sweep_step;
        logic put_wr;
        logic result_ld;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        act_t act;
        logic remain_nz;
        logic wb_pending;
    } sts_t;

    // Number of significant bytes in a value, zero for a zero value.
    function automatic logic [CFG_W-1:0] byte_len(input logic [VALUE_W-1:0] v);
        logic [CFG_W-1:0] n;
        n = '0;
        for (int i = 0; i < NUM_BYTES; i++) begin
            if (|v[8*i +: 8]) begin
                n = CFG_W'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

`default_nettype wire

/* hdl/bale_ram.sv */
// ----------------------------------------------------------------------------
// bale_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bale_ram #(
    parameter int WIDTH = bale_pkg::VALUE_W,
    parameter int DEPTH = bale_pkg::CAPACITY_DEF
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* hdl/bale_ctrl.sv */
// ----------------------------------------------------------------------------
// bale_ctrl
// Controller: sequences one command at a time through the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bounded_array_list_engine_defines.svh"

module bale_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  wire logic          m_ready,
    input  wire bale_pkg::sts_t sts,
    output bale_pkg::cmd_t     cmd
);

    bale_pkg::state_t state_reg, state_next;
    logic             m_valid_reg, m_valid_next;

    // State and result-valid registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bale_pkg::S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            bale_pkg::S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = bale_pkg::S_RUN;
                end
            end
            bale_pkg::S_RUN: begin
                case (sts.act)
                    bale_pkg::ACT_READ: begin
                        cmd.rd_issue = 1'b1;
                        state_next   = bale_pkg::S_READ_WAIT;
                    end
                    bale_pkg::ACT_PUT: begin
                        cmd.put_wr = 1'b1;
                        state_next = bale_pkg::S_FINISH;
                    end
                    bale_pkg::ACT_SHIFT_DN,
                    bale_pkg::ACT_SHIFT_UP,
                    bale_pkg::ACT_FILL: begin
                        state_next = bale_pkg::S_SWEEP;
                    end
                    default: begin
                        state_next = bale_pkg::S_FINISH;
                    end
                endcase
            end
            bale_pkg::S_READ_WAIT: begin
                cmd.rd_cap = 1'b1;
                state_next = bale_pkg::S_FINISH;
            end
            bale_pkg::S_SWEEP: begin
                // Step until the counter runs out, then let the last write-back drain.
                if (sts.remain_nz) begin
                    cmd.sweep_step = 1'b1;
                end else if (!sts.wb_pending) begin
                    state_next = (sts.act == bale_pkg::ACT_SHIFT_DN) ?
                                 bale_pkg::S_FINISH : bale_pkg::S_PUT;
                end
            end
            bale_pkg::S_PUT: begin
                cmd.put_wr = 1'b1;
                state_next = bale_pkg::S_FINISH;
            end
            bale_pkg::S_FINISH: begin
                // Load the result once the output register is free.
                if (!m_valid_reg || m_ready) begin
                    cmd.result_ld = 1'b1;
                    m_valid_next  = 1'b1;
                    state_next    = bale_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = bale_pkg::S_IDLE;
            end
        endcase
    end

    assign s_ready = (state_reg == bale_pkg::S_IDLE);
    assign m_valid = m_valid_reg;

    // A sweep that has run out of steps has no write-back pending in the next cycle.
    `BALE_ASSERT_NEXT(a_sweep_drains, aclk, aresetn, (state_reg == bale_pkg::S_SWEEP) && !sts.remain_nz, !sts.wb_pending, "write-back still pending after sweep end")
    // Finishing with a free output register always produces a result.
    `BALE_ASSERT_NEXT(a_finish_delivers, aclk, aresetn, (state_reg == bale_pkg::S_FINISH) && !m_valid_reg, m_valid_reg && (state_reg == bale_pkg::S_IDLE), "result not delivered from finish")

endmodule

`default_nettype wire

/* hdl/bale_dpath.sv */
// ----------------------------------------------------------------------------
// bale_dpath
// Datapath: command decode and checks, length and sweep counters, entry RAM.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bounded_array_list_engine_defines.svh"

module bale_dpath #(
    parameter int CAPACITY = bale_pkg::CAPACITY_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire bale_pkg::cmd_t                  cmd,
    output bale_pkg::sts_t                       sts,
    input  wire logic                            cfg_we,
    input  wire logic [bale_pkg::CFG_W-1:0]      cfg_wdata,
    input  wire logic [bale_pkg::OPCODE_W-1:0]   s_opcode,
    input  wire logic [bale_pkg::INDEX_W-1:0]    s_index,
    input  wire logic [bale_pkg::VALUE_W-1:0]    s_value,
    output logic      [bale_pkg::STATUS_W-1:0]   m_status,
    output logic      [bale_pkg::VALUE_W-1:0]    m_read_data,
    output logic      [bale_pkg::COUNT_W-1:0]    m_count
);

    localparam int LEN_W  = $clog2(CAPACITY + 1);
    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CW     = ((LEN_W > bale_pkg::INDEX_W) ? LEN_W : bale_pkg::INDEX_W) + 1;
    localparam int CNT_W  = bale_pkg::COUNT_W;

    // Control state.
    logic [bale_pkg::CFG_W-1:0] entry_bytes_reg;
    logic [LEN_W-1:0]           len_reg;
    logic                       wb_valid_reg;

    // Captured command.
    bale_pkg::act_t             act_reg;
    bale_pkg::status_t          st_reg;
    logic [LEN_W-1:0]           newlen_reg;
    logic [bale_pkg::VALUE_W-1:0] val_reg;
    logic [ADDR_W-1:0]          tgt_reg;
    logic [ADDR_W-1:0]          ptr_reg;
    logic [LEN_W-1:0]           remain_reg;
    logic [ADDR_W-1:0]          wb_addr_reg;
    logic [bale_pkg::VALUE_W-1:0] rd_res_reg;

    // Output register payload.
    logic [bale_pkg::STATUS_W-1:0] m_status_reg;
    logic [bale_pkg::VALUE_W-1:0]  m_read_data_reg;
    logic [CNT_W-1:0]              m_count_reg;

    // Decode signals.
    bale_pkg::opcode_t op;
    logic [CW-1:0]     idx_c, len_c, k_c, ins_len_c;
    logic [CW-1:0]     newlen_d, remain_d, ptr_d, tgt_d;
    logic              wide, in_range, empty, list_full, rm_ok;
    bale_pkg::act_t    act_d;
    bale_pkg::status_t st_d;

    // RAM port signals.
    logic                         ram_we, ram_re;
    logic [ADDR_W-1:0]            ram_wa, ram_ra;
    logic [bale_pkg::VALUE_W-1:0] ram_wd, ram_rd;
    logic                         fill_step, shift_step, shift_dn;

    // Checks and sweep setup for the command on the input ports.
    always_comb begin
        op        = bale_pkg::opcode_t'(s_opcode);
        idx_c     = CW'(s_index);
        len_c     = CW'(len_reg);
        k_c       = (op == bale_pkg::OP_REMOVE_FIRST) ? '0 : idx_c;
        wide      = !s_value[bale_pkg::VALUE_W-1] &&
                    (bale_pkg::byte_len(s_value) > entry_bytes_reg);
        in_range  = idx_c < len_c;
        empty     = (len_reg == '0);
        list_full = (len_c == CW'(CAPACITY));
        rm_ok     = k_c < len_c;
        ins_len_c = in_range ? len_c + CW'(1) : idx_c + CW'(1);

        st_d      = bale_pkg::ST_OK;
        act_d     = bale_pkg::ACT_NONE;
        newlen_d  = len_c;
        tgt_d     = idx_c;
        ptr_d     = len_c;
        remain_d  = '0;

        case (op)
            bale_pkg::OP_APPEND: begin
                if (wide) begin
                    st_d = bale_pkg::ST_WIDE;
                end else if (list_full) begin
                    st_d = bale_pkg::ST_FULL;
                end else begin
                    act_d    = bale_pkg::ACT_PUT;
                    tgt_d    = len_c;
                    newlen_d = len_c + CW'(1);
                end
            end
            bale_pkg::OP_REMOVE_LAST: begin
                if (empty) begin
                    st_d = bale_pkg::ST_RANGE;
                end else begin
                    newlen_d = len_c - CW'(1);
                end
            end
            bale_pkg::OP_REMOVE_FIRST,
            bale_pkg::OP_REMOVE_AT: begin
                if (!rm_ok) begin
                    st_d = bale_pkg::ST_RANGE;
                end else begin
                    act_d    = bale_pkg::ACT_SHIFT_DN;
                    newlen_d = len_c - CW'(1);
                    ptr_d    = k_c + CW'(1);
                    remain_d = len_c - CW'(1) - k_c;
                end
            end
            bale_pkg::OP_READ: begin
                if (!in_range) begin
                    st_d = bale_pkg::ST_RANGE;
                end else begin
                    act_d = bale_pkg::ACT_READ;
                end
            end
            bale_pkg::OP_OVERWRITE: begin
                if (wide) begin
                    st_d = bale_pkg::ST_WIDE;
                end else if (!in_range) begin
                    st_d = bale_pkg::ST_RANGE;
                end else begin
                    act_d = bale_pkg::ACT_PUT;
                end
            end
            bale_pkg::OP_INSERT: begin
                if (wide) begin
                    st_d = bale_pkg::ST_WIDE;
                end else if (ins_len_c > CW'(CAPACITY)) begin
                    st_d = bale_pkg::ST_FULL;
                end else begin
                    newlen_d = ins_len_c;
                    if (in_range) begin
                        // Move the tail up by one, last entry first.
                        act_d    = bale_pkg::ACT_SHIFT_UP;
                        ptr_d    = len_c - CW'(1);
                        remain_d = len_c - idx_c;
                    end else if (idx_c > len_c) begin
                        // Zero the gap between the old end and the index.
                        act_d    = bale_pkg::ACT_FILL;
                        ptr_d    = len_c;
                        remain_d = idx_c - len_c;
                    end else begin
                        act_d = bale_pkg::ACT_PUT;
                    end
                end
            end
            bale_pkg::OP_CLEAR: begin
                newlen_d = '0;
            end
            default: begin
                newlen_d = len_c;
            end
        endcase
    end

    // Configuration register, list length, write-back flag and captured action.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_bytes_reg <= bale_pkg::ENTRY_BYTES_RST;
            len_reg         <= '0;
            wb_valid_reg    <= 1'b0;
            act_reg         <= bale_pkg::ACT_NONE;
        end else begin
            if (cfg_we) begin
                entry_bytes_reg <= cfg_wdata;
            end
            if (cmd.result_ld) begin
                len_reg <= newlen_reg;
            end
            if (cmd.load) begin
                act_reg <= act_d;
            end
            wb_valid_reg <= shift_step;
        end
    end

    // Captured command fields, sweep counters, write-back address and read result.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            st_reg     <= st_d;
            newlen_reg <= LEN_W'(newlen_d);
            val_reg    <= s_value;
            tgt_reg    <= ADDR_W'(tgt_d);
            ptr_reg    <= ADDR_W'(ptr_d);
            remain_reg <= LEN_W'(remain_d);
        end else if (cmd.sweep_step) begin
            ptr_reg    <= (act_reg == bale_pkg::ACT_SHIFT_UP) ? ptr_reg - ADDR_W'(1)
                                                              : ptr_reg + ADDR_W'(1);
            remain_reg <= remain_reg - LEN_W'(1);
        end
        if (shift_step) begin
            wb_addr_reg <= shift_dn ? ptr_reg - ADDR_W'(1) : ptr_reg + ADDR_W'(1);
        end
        if (cmd.rd_cap) begin
            rd_res_reg <= ram_rd;
        end
    end

    // Output register payload.
    always_ff @(posedge aclk) begin
        if (cmd.result_ld) begin
            m_status_reg    <= st_reg;
            m_read_data_reg <= (act_reg == bale_pkg::ACT_READ) ? rd_res_reg : '0;
            m_count_reg     <= CNT_W'(newlen_reg);
        end
    end

    // Memory write and read selection.
    always_comb begin
        shift_dn   = (act_reg == bale_pkg::ACT_SHIFT_DN);
        shift_step = cmd.sweep_step && (shift_dn || (act_reg == bale_pkg::ACT_SHIFT_UP));
        fill_step  = cmd.sweep_step && (act_reg == bale_pkg::ACT_FILL);

        ram_we = 1'b0;
        ram_wa = tgt_reg;
        ram_wd = val_reg;
        if (wb_valid_reg) begin
            ram_we = 1'b1;
            ram_wa = wb_addr_reg;
            ram_wd = ram_rd;
        end else if (fill_step) begin
            ram_we = 1'b1;
            ram_wa = ptr_reg;
            ram_wd = '0;
        end else if (cmd.put_wr) begin
            ram_we = 1'b1;
        end

        ram_re = cmd.rd_issue || shift_step;
        ram_ra = cmd.rd_issue ? tgt_reg : ptr_reg;
    end

    bale_ram #(
        .WIDTH (bale_pkg::VALUE_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_wa),
        .wr_data (ram_wd),
        .rd_en   (ram_re),
        .rd_addr (ram_ra),
        .rd_data (ram_rd)
    );

    assign sts.act        = act_reg;
    assign sts.remain_nz  = (remain_reg != '0);
    assign sts.wb_pending = wb_valid_reg;

    assign m_status    = m_status_reg;
    assign m_read_data = m_read_data_reg;
    assign m_count     = m_count_reg;

    // A shift write-back never meets another write on the single write port.
    `BALE_ASSERT_IMPL(a_wr_port_free, aclk, aresetn, wb_valid_reg, !cmd.put_wr && !fill_step, "write port collision")
    // The list never grows past its capacity.
    `BALE_ASSERT_IMPL(a_len_bound, aclk, aresetn, 1'b1, len_reg <= LEN_W'(CAPACITY), "length exceeds capacity")
    // The reported count tracks the stored length.
    `BALE_ASSERT_NEXT(a_count_match, aclk, aresetn, cmd.result_ld, m_count_reg == CNT_W'(len_reg), "count does not match length")

endmodule

`default_nettype wire

/* hdl/bounded_array_list_engine.sv */
// A command goes from input transfer to result through the run and finish
// states; a read adds a read-wait state, a remove that moves entries adds a
// sweep state, and an insert that moves or zero-fills adds sweep and put states.
// One command is in work at a time; the next is taken as soon as the result is
// in the output register, and the entry RAM moves one entry per cycle. Reset
// clears the length to zero and sets entry_bytes to 8; entries are not cleared.
// ----------------------------------------------------------------------------
// bounded_array_list_engine
// Bounded ordered list of 64-bit entries with append, remove, read, overwrite,
// insert, remove-at-index and clear commands.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_array_list_engine #(
    parameter int CAPACITY = bale_pkg::CAPACITY_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // Configuration
    input  wire logic                            cfg_we,
    input  wire logic [bale_pkg::CFG_W-1:0]      cfg_wdata,
    // Command channel
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [bale_pkg::OPCODE_W-1:0]   s_opcode,
    input  wire logic [bale_pkg::INDEX_W-1:0]    s_index,
    input  wire logic [bale_pkg::VALUE_W-1:0]    s_value,
    // Result channel
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic      [bale_pkg::STATUS_W-1:0]   m_status,
    output logic      [bale_pkg::VALUE_W-1:0]    m_read_data,
    output logic      [bale_pkg::COUNT_W-1:0]    m_count
);

    bale_pkg::cmd_t cmd;
    bale_pkg::sts_t sts;

    // Command sequencer.
    bale_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Checks, counters, entry memory and result register.
    bale_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .s_opcode    (s_opcode),
        .s_index     (s_index),
        .s_value     (s_value),
        .m_status    (m_status),
        .m_read_data (m_read_data),
        .m_count     (m_count)
    );

endmodule

`default_nettype wire
